>>> rtl/core/csf_pkg.sv
// Shared types, role codes and register indexes of the correlated sampling tuple filter.
package csf_pkg;

    localparam int NUM_COLUMNS = 4;
    localparam int ROLE_BITS   = 2;

    localparam logic [60:0] MERSENNE61 = 61'h1FFF_FFFF_FFFF_FFFF;

    typedef logic [ROLE_BITS-1:0] role_t;
    typedef logic signed [31:0]   col_t;
    typedef logic [60:0]          hash_t;
    typedef logic [2:0]           reg_index_t;

    localparam role_t ROLE_IGNORE = 2'd0;
    localparam role_t ROLE_JOIN0  = 2'd1;
    localparam role_t ROLE_JOIN1  = 2'd2;
    localparam role_t ROLE_BOUND  = 2'd3;

    localparam reg_index_t REG_COLUMN_ROLES = 3'd0;
    localparam reg_index_t REG_SEED_MULT_0  = 3'd1;
    localparam reg_index_t REG_SEED_ADD_0   = 3'd2;
    localparam reg_index_t REG_SEED_MULT_1  = 3'd3;
    localparam reg_index_t REG_SEED_ADD_1   = 3'd4;
    localparam reg_index_t REG_THRESHOLD_0  = 3'd5;
    localparam reg_index_t REG_THRESHOLD_1  = 3'd6;
    localparam reg_index_t REG_BOUND_VALUE  = 3'd7;

    typedef struct packed {
        logic a;
        logic b;
        logic c;
        logic d;
    } stage_en_t;

    typedef struct packed {
        logic [60:0] mult;
        logic [60:0] add;
    } seed_t;

    function automatic role_t role_of(input logic [7:0] roles, input int col);
        role_t r;
        r = ROLE_IGNORE;
        if (col < 4)
        begin
            r = roles[col*ROLE_BITS +: ROLE_BITS];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/csf_lane.sv
// One hash lane: split multiply, wrap-around add, reduction mod 2^61-1.
module csf_lane
    import csf_pkg::*;
(
    input  logic      clk,
    input  stage_en_t en,
    input  col_t      col_value,
    input  seed_t     seed,
    output col_t      value_d,
    output hash_t     hash_d
);

    col_t        x_a_reg;
    col_t        x_b_reg;
    col_t        x_c_reg;
    col_t        x_d_reg;
    logic [63:0] prod_lo_reg;
    logic [63:0] prod_lo_next;
    logic [31:0] prod_hi_reg;
    logic [31:0] prod_hi_next;
    logic [31:0] corr_reg;
    logic [31:0] corr_next;
    logic [63:0] hash_c_reg;
    logic [63:0] hash_c_next;
    hash_t       hash_d_reg;
    hash_t       hash_d_next;
    logic [31:0] hi_word;
    logic [61:0] fold_sum;
    logic [61:0] fold_sum_p1;

    // x sign-extended: a*x = a*u - (neg ? a<<32 : 0) mod 2^64
    assign prod_lo_next = 64'(seed.mult[31:0]) * {32'd0, x_a_reg};
    assign prod_hi_next = 32'(seed.mult[60:32]) * x_a_reg;
    assign corr_next    = x_a_reg[31] ? seed.mult[31:0] : 32'd0;

    assign hi_word     = prod_hi_reg - corr_reg;
    assign hash_c_next = prod_lo_reg + {hi_word, 32'd0} + {3'd0, seed.add};

    assign fold_sum    = {1'b0, hash_c_reg[60:0]} + {59'd0, hash_c_reg[63:61]};
    assign fold_sum_p1 = fold_sum + 62'd1;
    assign hash_d_next = (fold_sum >= {1'b0, MERSENNE61}) ? fold_sum_p1[60:0] : fold_sum[60:0];

    always_ff @(posedge clk)
    begin
        if (en.a)
        begin
            x_a_reg <= col_value;
        end
        if (en.b)
        begin
            x_b_reg     <= x_a_reg;
            prod_lo_reg <= prod_lo_next;
            prod_hi_reg <= prod_hi_next;
            corr_reg    <= corr_next;
        end
        if (en.c)
        begin
            x_c_reg    <= x_b_reg;
            hash_c_reg <= hash_c_next;
        end
        if (en.d)
        begin
            x_d_reg    <= x_c_reg;
            hash_d_reg <= hash_d_next;
        end
    end

    assign value_d = x_d_reg;
    assign hash_d  = hash_d_reg;

endmodule

>>> rtl/core/csf_merge.sv
// Merge stage: threshold and bound checks across lanes, output register.
module csf_merge
    import csf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  logic        valid_d,
    input  col_t        value_d [NUM_COLUMNS],
    input  hash_t       hash_d  [NUM_COLUMNS],
    input  logic [7:0]  roles,
    input  hash_t       threshold_0,
    input  hash_t       threshold_1,
    input  col_t        bound_value,
    output logic        out_valid,
    output col_t        sampled   [NUM_COLUMNS]
);

    logic                   out_valid_reg;
    logic                   out_valid_next;
    col_t                   sampled_reg  [NUM_COLUMNS];
    col_t                   sampled_next [NUM_COLUMNS];
    logic [NUM_COLUMNS-1:0] lane_ok;

    always_comb
    begin
        for (int c = 0; c < NUM_COLUMNS; c++)
        begin
            lane_ok[c]      = 1'b1;
            sampled_next[c] = '0;
            case (role_of(roles, c))
                ROLE_JOIN0:
                begin
                    lane_ok[c]      = hash_d[c] < threshold_0;
                    sampled_next[c] = value_d[c];
                end
                ROLE_JOIN1:
                begin
                    lane_ok[c]      = hash_d[c] < threshold_1;
                    sampled_next[c] = value_d[c];
                end
                ROLE_BOUND:
                begin
                    lane_ok[c] = value_d[c] == bound_value;
                end
                default:
                begin
                    lane_ok[c] = 1'b1;
                end
            endcase
        end
    end

    assign out_valid_next = load ? (valid_d && (&lane_ok)) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            sampled_reg <= sampled_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sampled   = sampled_reg;

endmodule

>>> rtl/core/correlated_sampling_tuple_filter_unit.sv
// Top level of the correlated sampling tuple filter: config registers, pipeline control, lanes.
//
// Input channel: in_valid / in_stall with column_value_0..3, one tuple per item.
// Output channel: out_valid / out_stall with sampled_value_0..3; a tuple that
// passes every hash threshold and bound check yields one item, others yield none.
// Config channel: cfg_valid / cfg_ready with cfg_index and cfg_data; always ready.
// Write registers only while no tuple is in flight.
// Path from the accepting edge to out_valid, in order: the input register, then
// multiply, add, fold mod 2^61-1, compare and merge into the output register.
// Throughput: one item per cycle unless out_stall holds the output; each column has its
// own lane of two 32-bit multipliers, so all columns are hashed in the same cycle.
// While out_stall holds a result, the pipeline keeps filling its empty stages;
// in_stall rises only when all four stages and the output register are full.
// Reset clears all stage valid bits and out_valid, roles, seeds and bound to
// zero, thresholds to 2^61-1.
module correlated_sampling_tuple_filter_unit
    import csf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  reg_index_t  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  col_t        column_value_0,
    input  col_t        column_value_1,
    input  col_t        column_value_2,
    input  col_t        column_value_3,
    output logic        out_valid,
    input  logic        out_stall,
    output col_t        sampled_value_0,
    output col_t        sampled_value_1,
    output col_t        sampled_value_2,
    output col_t        sampled_value_3
);

    logic [7:0] column_roles_reg;
    hash_t      seed_mult_0_reg;
    hash_t      seed_add_0_reg;
    hash_t      seed_mult_1_reg;
    hash_t      seed_add_1_reg;
    hash_t      threshold_0_reg;
    hash_t      threshold_1_reg;
    col_t       bound_value_reg;

    logic       va_reg, vb_reg, vc_reg, vd_reg;
    logic       va_next, vb_next, vc_next, vd_next;
    logic       en_o;
    stage_en_t  en;
    logic       in_accept;

    col_t       col_in    [NUM_COLUMNS];
    col_t       value_d   [NUM_COLUMNS];
    hash_t      hash_d    [NUM_COLUMNS];
    col_t       sampled   [NUM_COLUMNS];
    seed_t      lane_seed [NUM_COLUMNS];

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            column_roles_reg <= '0;
            seed_mult_0_reg  <= '0;
            seed_add_0_reg   <= '0;
            seed_mult_1_reg  <= '0;
            seed_add_1_reg   <= '0;
            threshold_0_reg  <= MERSENNE61;
            threshold_1_reg  <= MERSENNE61;
            bound_value_reg  <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_COLUMN_ROLES: column_roles_reg <= cfg_data[7:0];
                REG_SEED_MULT_0:  seed_mult_0_reg  <= cfg_data[60:0];
                REG_SEED_ADD_0:   seed_add_0_reg   <= cfg_data[60:0];
                REG_SEED_MULT_1:  seed_mult_1_reg  <= cfg_data[60:0];
                REG_SEED_ADD_1:   seed_add_1_reg   <= cfg_data[60:0];
                REG_THRESHOLD_0:  threshold_0_reg  <= cfg_data[60:0];
                REG_THRESHOLD_1:  threshold_1_reg  <= cfg_data[60:0];
                REG_BOUND_VALUE:  bound_value_reg  <= cfg_data[31:0];
                default:          column_roles_reg <= column_roles_reg;
            endcase
        end
    end

    // a stage loads when it is empty or its content moves on
    assign en_o = !out_valid || !out_stall;
    assign en.d = !vd_reg || en_o;
    assign en.c = !vc_reg || en.d;
    assign en.b = !vb_reg || en.c;
    assign en.a = !va_reg || en.b;

    assign in_stall  = !en.a;
    assign in_accept = in_valid && !in_stall;

    assign va_next = en.a ? in_accept : va_reg;
    assign vb_next = en.b ? va_reg : vb_reg;
    assign vc_next = en.c ? vb_reg : vc_reg;
    assign vd_next = en.d ? vc_reg : vd_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
            vc_reg <= 1'b0;
            vd_reg <= 1'b0;
        end
        else
        begin
            va_reg <= va_next;
            vb_reg <= vb_next;
            vc_reg <= vc_next;
            vd_reg <= vd_next;
        end
    end

    assign col_in[0] = column_value_0;
    assign col_in[1] = column_value_1;
    assign col_in[2] = column_value_2;
    assign col_in[3] = column_value_3;

    always_comb
    begin
        for (int c = 0; c < NUM_COLUMNS; c++)
        begin
            if (role_of(column_roles_reg, c) == ROLE_JOIN1)
            begin
                lane_seed[c].mult = seed_mult_1_reg;
                lane_seed[c].add  = seed_add_1_reg;
            end
            else
            begin
                lane_seed[c].mult = seed_mult_0_reg;
                lane_seed[c].add  = seed_add_0_reg;
            end
        end
    end

    for (genvar g = 0; g < NUM_COLUMNS; g++)
    begin : g_lane
        csf_lane u_lane (
            .clk       (clk),
            .en        (en),
            .col_value (col_in[g]),
            .seed      (lane_seed[g]),
            .value_d   (value_d[g]),
            .hash_d    (hash_d[g])
        );
    end

    csf_merge u_merge (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (en_o),
        .valid_d     (vd_reg),
        .value_d     (value_d),
        .hash_d      (hash_d),
        .roles       (column_roles_reg),
        .threshold_0 (threshold_0_reg),
        .threshold_1 (threshold_1_reg),
        .bound_value (bound_value_reg),
        .out_valid   (out_valid),
        .sampled     (sampled)
    );

    assign sampled_value_0 = sampled[0];
    assign sampled_value_1 = sampled[1];
    assign sampled_value_2 = sampled[2];
    assign sampled_value_3 = sampled[3];

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (va_reg && vb_reg && vc_reg && vd_reg && out_valid && out_stall))
        else $error("input stalled with an empty stage");

    a_result_from_stage_d: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(vd_reg))
        else $error("result appeared without an item in the last stage");

    a_stage_d_held: assert property (@(posedge clk) disable iff (!rst_n)
        (vd_reg && out_valid && out_stall) |=> vd_reg)
        else $error("item lost from last stage while output stalled");

endmodule
